@@ hw/rtl/scpf_pkg.sv @@
// ----------------------------------------------------------------------------
// scpf_pkg: shared types and constants of the servo command packet framer
// Request codes, packet byte constants, scaling factors and the packet
// descriptor that travels from the front end to the serializer.
// ----------------------------------------------------------------------------
package scpf_pkg;

  localparam int unsigned ANGLE_W     = 9;
  localparam int unsigned RPM_W       = 7;
  localparam int unsigned POS_W       = 11;
  localparam int unsigned SPD_W       = 10;
  localparam int unsigned NUM_PARAMS  = 5;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned BYTE_IDX_W  = 4;

  // Configuration register indexes
  localparam logic CFG_LOWER = 1'b0;
  localparam logic CFG_UPPER = 1'b1;

  localparam logic [ANGLE_W-1:0] LOWER_RESET = 9'd0;
  localparam logic [ANGLE_W-1:0] UPPER_RESET = 9'd300;
  localparam logic [RPM_W-1:0]   MAX_RPM     = 7'd114;

  // x*1023/360 and x*1023/114 as exact reciprocal multiplications
  localparam logic [29:0] POS_MULT  = 30'd762805065;
  localparam int unsigned POS_SHIFT = 28;
  localparam int unsigned POS_PROD_W = ANGLE_W + 30;
  localparam logic [27:0] SPD_MULT  = 28'd150553887;
  localparam int unsigned SPD_SHIFT = 24;
  localparam int unsigned SPD_PROD_W = RPM_W + 28;

  localparam logic [7:0] HDR_BYTE  = 8'hFF;
  localparam logic [7:0] INS_WRITE = 8'h03;
  localparam logic [7:0] INS_READ  = 8'h02;
  localparam logic [7:0] REG_GOAL  = 8'h1E;
  localparam logic [7:0] LEN_MOVE  = 8'h07;
  localparam logic [7:0] LEN_READ  = 8'h04;

  // Byte positions inside a packet
  localparam logic [BYTE_IDX_W-1:0] BYTE_HDR0  = 4'd0;
  localparam logic [BYTE_IDX_W-1:0] BYTE_HDR1  = 4'd1;
  localparam logic [BYTE_IDX_W-1:0] BYTE_ID    = 4'd2;
  localparam logic [BYTE_IDX_W-1:0] BYTE_LEN   = 4'd3;
  localparam logic [BYTE_IDX_W-1:0] BYTE_INS   = 4'd4;
  localparam logic [BYTE_IDX_W-1:0] BYTE_PAR0  = 4'd5;
  localparam logic [BYTE_IDX_W-1:0] BYTE_PAR1  = 4'd6;
  localparam logic [BYTE_IDX_W-1:0] BYTE_PAR2  = 4'd7;
  localparam logic [BYTE_IDX_W-1:0] BYTE_PAR3  = 4'd8;
  localparam logic [BYTE_IDX_W-1:0] BYTE_PAR4  = 4'd9;
  localparam logic [BYTE_IDX_W-1:0] LAST_MOVE  = 4'd10;
  localparam logic [BYTE_IDX_W-1:0] LAST_READ  = 4'd7;

  typedef enum logic [2:0] {
    REQ_MOVE       = 3'd0,
    REQ_READ_ANGLE = 3'd1,
    REQ_READ_SPEED = 3'd2,
    REQ_READ_DELAY = 3'd3,
    REQ_READ_VOLT  = 3'd4,
    REQ_READ_TEMP  = 3'd5
  } req_e;

  typedef struct packed {
    logic [7:0]                  id;
    logic [7:0]                  len_byte;
    logic [7:0]                  ins;
    logic [NUM_PARAMS-1:0][7:0]  param;
    logic [BYTE_IDX_W-1:0]       last_idx;
  } pkt_desc_t;

  function automatic logic [7:0] read_addr(input req_e req);
    logic [7:0] a;
    unique case (req)
      REQ_READ_ANGLE: a = 8'h24;
      REQ_READ_SPEED: a = 8'h26;
      REQ_READ_DELAY: a = 8'h05;
      REQ_READ_VOLT:  a = 8'h2A;
      REQ_READ_TEMP:  a = 8'h2B;
      default:        a = 8'h00;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] read_len(input req_e req);
    logic [7:0] l;
    case (req) inside
      REQ_READ_ANGLE, REQ_READ_SPEED: l = 8'h02;
      default:                        l = 8'h01;
    endcase
    return l;
  endfunction

endpackage

@@ hw/rtl/scpf_front.sv @@
// ----------------------------------------------------------------------------
// scpf_front: command intake and packet classification
// Clamps and saturates the command, scales angle and speed, and builds the
// packet descriptor in a two-stage pipeline feeding the queue.
// ----------------------------------------------------------------------------
module scpf_front
  import scpf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [ANGLE_W-1:0] lower_limit_i,
  input  logic [ANGLE_W-1:0] upper_limit_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [7:0]         servo_id_i,
  input  logic [ANGLE_W-1:0] target_angle_i,
  input  logic [RPM_W-1:0]   target_rpm_i,
  output logic               push_o,
  input  logic               queue_full_i,
  output pkt_desc_t          desc_o
);

  logic               s1_v_q, s1_v_d;
  req_e               s1_req_q;
  logic [7:0]         s1_id_q;
  logic [ANGLE_W-1:0] s1_ang_q, ang_clamped;
  logic [RPM_W-1:0]   s1_rpm_q, rpm_sat;
  logic               s2_v_q, s2_v_d;
  pkt_desc_t          s2_desc_q, desc_d;
  logic               s1_ready, s2_ready, accept;
  logic [POS_PROD_W-1:0] pos_prod;
  logic [SPD_PROD_W-1:0] spd_prod;
  logic [POS_W-1:0]   pos;
  logic [SPD_W-1:0]   spd;

  assign s2_ready   = !s2_v_q || !queue_full_i;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign accept     = in_valid_i && s1_ready;

  // Upper limit is tested first
  always_comb begin
    if (target_angle_i > upper_limit_i) begin
      ang_clamped = upper_limit_i;
    end else if (target_angle_i < lower_limit_i) begin
      ang_clamped = lower_limit_i;
    end else begin
      ang_clamped = target_angle_i;
    end
    rpm_sat = (target_rpm_i > MAX_RPM) ? MAX_RPM : target_rpm_i;
  end

  // Drop unused request codes at intake
  always_comb begin
    s1_v_d = s1_v_q;
    if (s1_ready) begin
      s1_v_d = accept && (req_type_i <= 3'(REQ_READ_TEMP));
    end
    s2_v_d = s2_v_q;
    if (s2_ready) begin
      s2_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= req_e'(req_type_i);
      s1_id_q  <= servo_id_i;
      s1_ang_q <= ang_clamped;
      s1_rpm_q <= rpm_sat;
    end
    if (s2_ready && s1_v_q) begin
      s2_desc_q <= desc_d;
    end
  end

  assign pos_prod = POS_PROD_W'(s1_ang_q) * POS_PROD_W'(POS_MULT);
  assign spd_prod = SPD_PROD_W'(s1_rpm_q) * SPD_PROD_W'(SPD_MULT);
  assign pos      = pos_prod[POS_SHIFT +: POS_W];
  assign spd      = spd_prod[SPD_SHIFT +: SPD_W];

  always_comb begin
    desc_d    = '0;
    desc_d.id = s1_id_q;
    if (s1_req_q == REQ_MOVE) begin
      desc_d.len_byte = LEN_MOVE;
      desc_d.ins      = INS_WRITE;
      desc_d.param[0] = REG_GOAL;
      desc_d.param[1] = pos[7:0];
      desc_d.param[2] = 8'(pos[POS_W-1:8]);
      desc_d.param[3] = spd[7:0];
      desc_d.param[4] = 8'(spd[SPD_W-1:8]);
      desc_d.last_idx = LAST_MOVE;
    end else begin
      desc_d.len_byte = LEN_READ;
      desc_d.ins      = INS_READ;
      desc_d.param[0] = read_addr(s1_req_q);
      desc_d.param[1] = read_len(s1_req_q);
      desc_d.last_idx = LAST_READ;
    end
  end

  assign push_o = s2_v_q && !queue_full_i;
  assign desc_o = s2_desc_q;

endmodule

@@ hw/rtl/scpf_queue.sv @@
// ----------------------------------------------------------------------------
// scpf_queue: descriptor queue between front end and serializer
// Small register FIFO; lets each side stall independently.
// ----------------------------------------------------------------------------
module scpf_queue
  import scpf_pkg::*;
#(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  pkt_desc_t push_desc_i,
  input  logic      pop_i,
  output pkt_desc_t head_desc_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pkt_desc_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o      = (cnt_q == CntW'(Depth));
  assign empty_o     = (cnt_q == '0);
  assign head_desc_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? bump(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? bump(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

@@ hw/rtl/scpf_back.sv @@
// ----------------------------------------------------------------------------
// scpf_back: packet serializer
// Walks the head descriptor byte by byte into the output register and
// accumulates the checksum on the fly.
// ----------------------------------------------------------------------------
module scpf_back
  import scpf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pkt_desc_t head_desc_i,
  input  logic      head_valid_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output logic [7:0] tx_byte_o,
  output logic      last_byte_o
);

  logic [BYTE_IDX_W-1:0] cnt_q, cnt_d;
  logic [7:0]            sum_q, sum_d;
  logic                  out_v_q, out_v_d;
  logic [7:0]            tx_q, tx_d;
  logic                  last_q, last_d;
  logic [7:0]            cur_byte;
  logic                  adv, is_last, load;

  assign adv     = !out_v_q || !out_stall_i;
  assign load    = adv && head_valid_i;
  assign is_last = (cnt_q == head_desc_i.last_idx);
  assign pop_o   = load && is_last;

  always_comb begin
    case (cnt_q) inside
      BYTE_HDR0, BYTE_HDR1: cur_byte = HDR_BYTE;
      BYTE_ID:   cur_byte = head_desc_i.id;
      BYTE_LEN:  cur_byte = head_desc_i.len_byte;
      BYTE_INS:  cur_byte = head_desc_i.ins;
      BYTE_PAR0: cur_byte = head_desc_i.param[0];
      BYTE_PAR1: cur_byte = head_desc_i.param[1];
      BYTE_PAR2: cur_byte = head_desc_i.param[2];
      BYTE_PAR3: cur_byte = head_desc_i.param[3];
      BYTE_PAR4: cur_byte = head_desc_i.param[4];
      default:   cur_byte = '0;
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    tx_d    = tx_q;
    last_d  = last_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    if (adv) begin
      out_v_d = head_valid_i;
    end
    if (load) begin
      tx_d   = is_last ? ~sum_q : cur_byte;
      last_d = is_last;
      cnt_d  = is_last ? '0 : cnt_q + 1'b1;
      // Restart the sum on the header bytes
      sum_d  = (cnt_q < BYTE_ID) ? '0 : sum_q + cur_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      out_v_q <= out_v_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tx_q   <= tx_d;
    last_q <= last_d;
    sum_q  <= sum_d;
  end

  assign out_valid_o = out_v_q;
  assign tx_byte_o   = tx_q;
  assign last_byte_o = last_q;

endmodule

@@ hw/rtl/servo_command_packet_framer_unit.sv @@
// ----------------------------------------------------------------------------
// servo_command_packet_framer_unit: servo instruction packet framer
// Turns one servo command into its instruction packet, one byte per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one command per transfer.
//   A move yields 11 bytes: FF FF id 07 03 1E posL posH spdL spdH sum; the
//   five reads yield 8 bytes: FF FF id 04 02 addr len sum. Request codes 6
//   and 7 are dropped and yield nothing.
//   Output channel (out_valid_o / out_stall_i) carries one byte per transfer;
//   last_byte_o marks the checksum byte.
//   Each command goes through both front-end stages, the queue and tx_q.
//   Throughput: the serializer moves one byte per cycle while out_stall_i is
//   low, with no gap between packets; the output port sets this rate.
//   Commands are taken back to back until the two pipeline stages and the
//   descriptor queue (QueueDepth entries) fill.
//   A stalled output holds its byte; the queue then fills and in_stall_o
//   rises. Reset empties the pipeline, the queue and the output register and
//   loads the angle limits with 0 and 300 degrees.
//   Configuration: write the limits only while the block is idle.
// ----------------------------------------------------------------------------
module servo_command_packet_framer_unit
  import scpf_pkg::*;
#(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [ANGLE_W-1:0] cfg_wdata_i,
  // Command channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [7:0]         servo_id_i,
  input  logic [ANGLE_W-1:0] target_angle_i,
  input  logic [RPM_W-1:0]   target_rpm_i,
  // Byte channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         tx_byte_o,
  output logic               last_byte_o
);

  logic [ANGLE_W-1:0] lower_q, lower_d, upper_q, upper_d;
  logic               q_push, q_pop, q_full, q_empty;
  pkt_desc_t          push_desc, head_desc;

  // Limit registers
  always_comb begin
    lower_d = lower_q;
    upper_d = upper_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LOWER: lower_d = cfg_wdata_i;
        CFG_UPPER: upper_d = cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= LOWER_RESET;
      upper_q <= UPPER_RESET;
    end else begin
      lower_q <= lower_d;
      upper_q <= upper_d;
    end
  end

  // Front end: clamp, scale, classify
  scpf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .lower_limit_i  (lower_q),
    .upper_limit_i  (upper_q),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .servo_id_i     (servo_id_i),
    .target_angle_i (target_angle_i),
    .target_rpm_i   (target_rpm_i),
    .push_o         (q_push),
    .queue_full_i   (q_full),
    .desc_o         (push_desc)
  );

  // Decouple intake from the byte stream
  scpf_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .pop_i       (q_pop),
    .head_desc_o (head_desc),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // Back end: serialize and append the checksum
  scpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_desc_i  (head_desc),
    .head_valid_i (!q_empty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_byte_o    (tx_byte_o),
    .last_byte_o  (last_byte_o)
  );

  // Never write into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full queue");

  // Never retire a descriptor that is not there
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  // Intake holds off only when the queue is backed up
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> q_full)
    else $error("intake stalled with queue space left");

  // A packet ends only when its descriptor retires
  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> (out_valid_o && last_byte_o))
    else $error("retired descriptor without a checksum byte");

endmodule

@@ dv/servo_command_packet_framer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// servo_command_packet_framer_unit_tb: packet framer block-level testbench
// Drives servo commands through the command channel in random bursts and
// checks every transferred packet byte against a byte-exact prediction of the
// move and read packets, under several angle-limit settings and output stalls.
// ----------------------------------------------------------------------------
module servo_command_packet_framer_unit_tb
  import scpf_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]         req;
    logic [7:0]         id;
    logic [ANGLE_W-1:0] ang;
    logic [RPM_W-1:0]   rpm;
  } servo_cmd_t;

  // Holds the angle limits as last written and the bytes still owed by the
  // block, oldest first.
  class packet_scoreboard;
    typedef struct packed {
      logic [7:0] tx_byte;
      logic       last_byte;
    } pkt_byte_t;

    pkt_byte_t          owed_bytes[$];
    logic [ANGLE_W-1:0] lower_lim;
    logic [ANGLE_W-1:0] upper_lim;
    int unsigned        errors;
    int unsigned        bytes_checked;
    int unsigned        moves;
    int unsigned        reads;
    int unsigned        dropped;

    function new();
      lower_lim = LOWER_RESET;
      upper_lim = UPPER_RESET;
      errors = 0;
      bytes_checked = 0;
      moves = 0;
      reads = 0;
      dropped = 0;
    endfunction

    function void set_limit(logic idx, logic [ANGLE_W-1:0] value);
      if (idx == CFG_LOWER) lower_lim = value;
      else upper_lim = value;
    endfunction

    // Work out the full packet for one accepted command and queue its bytes.
    function void note_command(servo_cmd_t c);
      logic [7:0]  pkt[11];
      int unsigned n;
      int unsigned a;
      int unsigned r;
      int unsigned pos;
      int unsigned spd;
      logic [7:0]  sum;
      req_e        kind;
      if (c.req > REQ_READ_TEMP) begin
        dropped++;
        return;
      end
      kind = req_e'(c.req);
      pkt[0] = HDR_BYTE;
      pkt[1] = HDR_BYTE;
      pkt[2] = c.id;
      if (kind == REQ_MOVE) begin
        a = c.ang;
        // Upper limit wins when the limits cross
        if (a > upper_lim) a = upper_lim;
        else if (a < lower_lim) a = lower_lim;
        r = (c.rpm > MAX_RPM) ? MAX_RPM : c.rpm;
        pos = a * 1023 / 360;
        spd = r * 1023 / 114;
        pkt[3] = LEN_MOVE;
        pkt[4] = INS_WRITE;
        pkt[5] = REG_GOAL;
        pkt[6] = pos[7:0];
        pkt[7] = pos[15:8];
        pkt[8] = spd[7:0];
        pkt[9] = spd[15:8];
        n = 11;
        moves++;
      end else begin
        pkt[3] = LEN_READ;
        pkt[4] = INS_READ;
        case (kind)
          REQ_READ_ANGLE: begin pkt[5] = 8'h24; pkt[6] = 8'h02; end
          REQ_READ_SPEED: begin pkt[5] = 8'h26; pkt[6] = 8'h02; end
          REQ_READ_DELAY: begin pkt[5] = 8'h05; pkt[6] = 8'h01; end
          REQ_READ_VOLT:  begin pkt[5] = 8'h2A; pkt[6] = 8'h01; end
          default:        begin pkt[5] = 8'h2B; pkt[6] = 8'h01; end
        endcase
        n = 8;
        reads++;
      end
      sum = 8'd0;
      for (int i = 2; i < n - 1; i++) sum += pkt[i];
      pkt[n-1] = ~sum;
      for (int i = 0; i < n; i++) owed_bytes.push_back({pkt[i], (i == n - 1) ? 1'b1 : 1'b0});
    endfunction

    function void check_byte(logic [7:0] tx, logic last);
      pkt_byte_t exp_b;
      bytes_checked++;
      if (owed_bytes.size() == 0) begin
        $error("unexpected byte transfer: tx_byte=%h last_byte=%b", tx, last);
        errors++;
        return;
      end
      exp_b = owed_bytes.pop_front();
      if (tx !== exp_b.tx_byte) begin
        $error("tx_byte mismatch: expected %h, actual %h", exp_b.tx_byte, tx);
        errors++;
      end
      if (last !== exp_b.last_byte) begin
        $error("last_byte mismatch: expected %b, actual %b", exp_b.last_byte, last);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = CFG_LOWER;
  logic [ANGLE_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         req_type_i = '0;
  logic [7:0]         servo_id_i = '0;
  logic [ANGLE_W-1:0] target_angle_i = '0;
  logic [RPM_W-1:0]   target_rpm_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [7:0]         tx_byte_o;
  logic               last_byte_o;

  packet_scoreboard sb = new();
  int unsigned      settings_run = 0;

  servo_command_packet_framer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .servo_id_i    (servo_id_i),
    .target_angle_i(target_angle_i),
    .target_rpm_i  (target_rpm_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .tx_byte_o     (tx_byte_o),
    .last_byte_o   (last_byte_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver stall pattern: pick a mode for a random stretch of cycles -
  // no stalls, sparse stalls, coin-flip stalls, or runs set by stall_left[3].
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: out_stall_i = 1'b0;
      1: out_stall_i = ($urandom_range(0, 7) == 0);
      2: out_stall_i = 1'($urandom_range(0, 1));
      default: out_stall_i = stall_left[3];
    endcase
  end

  // Check every byte transfer at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_byte(tx_byte_o, last_byte_o);
  end

  // Present one command and hold it until the block takes the transfer.
  task automatic send_cmd(logic [2:0] req, logic [7:0] id, logic [ANGLE_W-1:0] ang,
                          logic [RPM_W-1:0] rpm);
    servo_cmd_t c;
    c = '{req: req, id: id, ang: ang, rpm: rpm};
    @(negedge clk_i);
    in_valid_i     = 1'b1;
    req_type_i     = c.req;
    servo_id_i     = c.id;
    target_angle_i = c.ang;
    target_rpm_i   = c.rpm;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_command(c);
  endtask

  // Drop valid for a number of cycles and scramble the idle payload.
  task automatic idle_gap(int unsigned cycles);
    for (int i = 0; i < cycles; i++) begin
      @(negedge clk_i);
      in_valid_i     = 1'b0;
      req_type_i     = 3'($urandom());
      servo_id_i     = 8'($urandom());
      target_angle_i = ANGLE_W'($urandom());
      target_rpm_i   = RPM_W'($urandom());
    end
  endtask

  // Hold off the sender until every owed byte is out, then let any dropped
  // command clear the pipeline.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.owed_bytes.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_limits(logic [ANGLE_W-1:0] lower, logic [ANGLE_W-1:0] upper);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = CFG_LOWER;
    cfg_wdata_i = lower;
    @(negedge clk_i);
    cfg_idx_i   = CFG_UPPER;
    cfg_wdata_i = upper;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    sb.set_limit(CFG_LOWER, lower);
    sb.set_limit(CFG_UPPER, upper);
    settings_run++;
  endtask

  // Random commands in bursts; unused request codes do not count.
  task automatic random_phase(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned r;
    logic [2:0]  req;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst; i++) begin
        r = $urandom_range(0, 19);
        if (r < 8) req = REQ_MOVE;
        else if (r < 18) req = 3'(1 + r % 5);
        else req = 3'(6 + r % 2);
        send_cmd(req, 8'($urandom()), ANGLE_W'($urandom()), RPM_W'($urandom()));
        if (req <= REQ_READ_TEMP) sent++;
      end
      if ($urandom_range(0, 9) == 0) idle_gap($urandom_range(15, 30));
      else idle_gap($urandom_range(0, 5));
    end
  endtask

  initial begin
    logic [ANGLE_W-1:0] lo;
    logic [ANGLE_W-1:0] hi;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset limits 0..300: field extremes, every read, unused codes.
    send_cmd(REQ_MOVE, 8'h00, 9'd0, 7'd0);
    send_cmd(REQ_MOVE, 8'hFF, 9'd511, 7'd127);
    send_cmd(REQ_MOVE, 8'h5A, 9'd300, 7'd114);
    send_cmd(REQ_MOVE, 8'hA5, 9'd301, 7'd115);
    send_cmd(REQ_MOVE, 8'h01, 9'd180, 7'd57);
    send_cmd(REQ_READ_ANGLE, 8'hFE, 9'd0, 7'd0);
    send_cmd(REQ_READ_SPEED, 8'h00, 9'd511, 7'd127);
    send_cmd(REQ_READ_DELAY, 8'h7F, 9'd0, 7'd0);
    send_cmd(REQ_READ_VOLT, 8'h80, 9'd0, 7'd0);
    send_cmd(REQ_READ_TEMP, 8'hFF, 9'd0, 7'd0);
    send_cmd(3'd6, 8'h12, 9'd100, 7'd10);
    send_cmd(3'd7, 8'h34, 9'd200, 7'd20);
    send_cmd(REQ_MOVE, 8'h42, 9'd1, 7'd1);
    drain();

    // Crossed limits: upper test comes first.
    write_limits(9'd200, 9'd100);
    send_cmd(REQ_MOVE, 8'h10, 9'd150, 7'd30);
    send_cmd(REQ_MOVE, 8'h11, 9'd50, 7'd60);
    send_cmd(REQ_MOVE, 8'h12, 9'd100, 7'd90);
    drain();

    // Wide-open limits: angles past 360 scale past full range.
    write_limits(9'd0, 9'd511);
    send_cmd(REQ_MOVE, 8'h20, 9'd511, 7'd114);
    send_cmd(REQ_MOVE, 8'h21, 9'd361, 7'd0);
    send_cmd(REQ_MOVE, 8'h22, 9'd360, 7'd127);
    drain();

    // Both limits pinned at the top of the normal range.
    write_limits(9'd360, 9'd360);
    send_cmd(REQ_MOVE, 8'h30, 9'd0, 7'd113);
    send_cmd(REQ_MOVE, 8'h31, 9'd511, 7'd2);
    drain();

    // Random phases, each under its own limits.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin lo = 9'd0; hi = 9'd360; end
        1: begin lo = 9'd511; hi = 9'd0; end
        default: begin
          lo = 9'($urandom_range(0, 360));
          hi = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                          : 9'($urandom_range(lo, 360));
        end
      endcase
      write_limits(lo, hi);
      random_phase(50);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.owed_bytes.size() != 0) begin
      $error("%0d expected bytes never arrived", sb.owed_bytes.size());
      sb.errors++;
    end

    $display("covered %0d moves, %0d reads, %0d dropped codes; %0d bytes checked",
             sb.moves, sb.reads, sb.dropped, sb.bytes_checked);
    $display("under %0d limit settings, with random bursts and output stalls", settings_run);
    if (sb.errors == 0) begin
      $display("servo_command_packet_framer_unit test passed");
    end else begin
      $display("servo_command_packet_framer_unit test failed");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #(5_000_000);
    $display("servo_command_packet_framer_unit test failed");
    $finish;
  end

endmodule
